/* sv/lpd_pkg.sv */
// Shared constants for the Lp-norm distance energy and gradient block.
// No dependencies; imported by every module of the block.
package lpd_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int SUM_BITS_DEF   = 48;

	localparam int ORDER_W = 4;
	localparam logic [ORDER_W-1:0] ORDER_MIN   = 4'd2;
	localparam logic [ORDER_W-1:0] ORDER_MAX   = 4'd8;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd2;

	// width of the operand slice fed to the shared multiplier each cycle
	localparam int MUL_CHUNK = 32;

endpackage

/* sv/lpd_mul.sv */
// Multi-cycle saturating fixed-point multiplier: y = min((a*b) >> FRAC_BITS, 2^SUM_BITS-1).
// One MUL_CHUNK x COORD_BITS product per cycle, high slice first. Uses lpd_pkg.
module lpd_mul #(
	parameter int COORD_BITS = lpd_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lpd_pkg::FRAC_BITS_DEF,
	parameter int SUM_BITS   = lpd_pkg::SUM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_BITS-1:0]   a,
	input  logic [COORD_BITS-1:0] b,
	output logic                  done,
	output logic [SUM_BITS-1:0]   y
);
	import lpd_pkg::*;

	localparam int NCH = (SUM_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PAD = NCH * MUL_CHUNK;
	localparam int AW  = SUM_BITS + COORD_BITS;
	localparam int CW  = $clog2(NCH + 1);

	logic [PAD-1:0]              a_q;
	logic [COORD_BITS-1:0]       b_q;
	logic [AW-1:0]               acc_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [MUL_CHUNK+COORD_BITS-1:0] pp;
	logic [AW-1:0]               acc_nx;
	logic [AW-1:0]               shifted;

	assign pp      = a_q[PAD-1 -: MUL_CHUNK] * b_q;
	assign acc_nx  = (acc_q << MUL_CHUNK) + AW'(pp);
	assign shifted = acc_q >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NCH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PAD'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q << MUL_CHUNK;
			acc_q <= acc_nx;
		end
	end

	assign done = done_q;
	assign y    = (shifted[AW-1:SUM_BITS] != '0) ? '1 : shifted[SUM_BITS-1:0];

endmodule

/* sv/lpd_div.sv */
// Bit-serial restoring divider: quotient of the running sum by the order p.
// One quotient bit per cycle while busy. Uses lpd_pkg.
module lpd_div #(
	parameter int SUM_BITS = lpd_pkg::SUM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [SUM_BITS-1:0]         dividend,
	input  logic [lpd_pkg::ORDER_W-1:0] divisor,
	output logic                        done,
	output logic [SUM_BITS-1:0]         quot
);
	import lpd_pkg::*;

	localparam int CW = $clog2(SUM_BITS + 1);

	logic [SUM_BITS-1:0] q_q;
	logic [ORDER_W-1:0]  rem_q;
	logic [ORDER_W-1:0]  div_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ORDER_W:0]    rem_sh;
	logic [ORDER_W:0]    rem_sub;
	logic                ge;

	assign rem_sh  = {rem_q, q_q[SUM_BITS-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(SUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[SUM_BITS-2:0], ge};
			rem_q <= ge ? rem_sub[ORDER_W-1:0] : rem_sh[ORDER_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

/* sv/p_norm_distance_energy_gradient.sv */
// Lp-norm distance energy and gradient, top level: sequencer, sum, output register.
// Each accepted word takes p-1 products from the shared multiplier, each in NCH = ceil(SUM_BITS/32)
// slices, and then the sum; a last word adds the serial divide by p before the output register.
// One word in flight; the next word is taken in the cycle after the result is registered.
// Async active-low reset: order = 2, sum = 0, no word held, input ready.
// Depends on lpd_pkg, lpd_mul, lpd_div.
module p_norm_distance_energy_gradient #(
	parameter int COORD_BITS = lpd_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lpd_pkg::FRAC_BITS_DEF,
	parameter int SUM_BITS   = lpd_pkg::SUM_BITS_DEF,
	localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((COORD_BITS + SUM_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [IN_W-1:0]             s_tdata,   // coordinate, target_coordinate
	input  logic                        s_tlast,   // last
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUT_W-1:0]            m_tdata,   // gradient_element, energy_value
	output logic                        m_tlast,   // final_res
	input  logic                        cfg_wen,
	input  logic [lpd_pkg::ORDER_W-1:0] cfg_wdata
);
	import lpd_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MGO    = 3'd1;
	localparam logic [2:0] ST_MWAIT  = 3'd2;
	localparam logic [2:0] ST_SUM    = 3'd3;
	localparam logic [2:0] ST_DGO    = 3'd4;
	localparam logic [2:0] ST_DWAIT  = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	localparam logic [SUM_BITS-1:0] NEG_LIM = SUM_BITS'(1) << (COORD_BITS - 1);
	localparam logic [SUM_BITS-1:0] POS_LIM = NEG_LIM - SUM_BITS'(1);

	logic [2:0]            state_q;
	logic [ORDER_W-1:0]    order_q;
	logic [ORDER_W-1:0]    cnt_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [COORD_BITS-1:0] mag_q;
	logic                  neg_q;
	logic                  last_q;
	logic [SUM_BITS-1:0]   pw_q;
	logic [SUM_BITS-1:0]   term_q;
	logic [SUM_BITS-1:0]   quot_q;
	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;
	logic                  m_last_q;

	logic                  accept;
	logic [COORD_BITS-1:0] s_coord;
	logic [COORD_BITS-1:0] s_target;
	logic [COORD_BITS:0]   diff;
	logic [COORD_BITS:0]   diff_abs;
	logic [SUM_BITS:0]     sum_add;
	logic [SUM_BITS-1:0]   sum_sat;
	logic [SUM_BITS-1:0]   gmag;
	logic [COORD_BITS-1:0] grad;
	logic [SUM_BITS-1:0]   energy;
	logic                  out_free;
	logic                  mul_start;
	logic                  mul_done;
	logic [SUM_BITS-1:0]   mul_y;
	logic                  div_start;
	logic                  div_done;
	logic [SUM_BITS-1:0]   div_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign s_coord   = s_tdata[COORD_BITS-1:0];
	assign s_target  = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign diff      = {s_coord[COORD_BITS-1], s_coord} - {s_target[COORD_BITS-1], s_target};
	assign diff_abs  = diff[COORD_BITS] ? (~diff + 1'b1) : diff;

	assign sum_add   = {1'b0, sum_q} + {1'b0, term_q};
	assign sum_sat   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];

	assign gmag      = neg_q ? ((pw_q > NEG_LIM) ? NEG_LIM : pw_q)
	                         : ((pw_q > POS_LIM) ? POS_LIM : pw_q);
	assign grad      = neg_q ? (~gmag[COORD_BITS-1:0] + 1'b1) : gmag[COORD_BITS-1:0];
	assign energy    = last_q ? quot_q : '0;

	assign out_free  = !m_valid_q || m_tready;
	assign mul_start = (state_q == ST_MGO);
	assign div_start = (state_q == ST_DGO);

	lpd_mul #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.SUM_BITS  (SUM_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (pw_q),
		.b     (mag_q),
		.done  (mul_done),
		.y     (mul_y)
	);

	lpd_div #(
		.SUM_BITS(SUM_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (order_q),
		.done    (div_done),
		.quot    (div_q)
	);

	// order register, clamped to 2..8
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg_wen) begin
			if (cfg_wdata < ORDER_MIN)
				order_q <= ORDER_MIN;
			else if (cfg_wdata > ORDER_MAX)
				order_q <= ORDER_MAX;
			else
				order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			sum_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= order_q - 1'b1;
						state_q <= ST_MGO;
					end
				end
				ST_MGO: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mul_done) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= (cnt_q == ORDER_W'(1)) ? ST_SUM : ST_MGO;
					end
				end
				ST_SUM: begin
					sum_q   <= sum_sat;
					state_q <= last_q ? ST_DGO : ST_FIN;
				end
				ST_DGO: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						if (last_q)
							sum_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= diff_abs[COORD_BITS-1:0];
			neg_q  <= diff[COORD_BITS];
			last_q <= s_tlast;
			pw_q   <= SUM_BITS'(diff_abs[COORD_BITS-1:0]);
		end
		if (state_q == ST_MWAIT && mul_done) begin
			if (cnt_q == ORDER_W'(1))
				term_q <= mul_y;
			else
				pw_q <= mul_y;
		end
		if (state_q == ST_DWAIT && div_done)
			quot_q <= div_q;
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= OUT_W'({energy, grad});
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

/* sv/lpd_checker.sv */
// Port-level checks for p_norm_distance_energy_gradient, bound to the top level.
// Depends on lpd_pkg and the top level's ports.
module lpd_checker #(
	parameter int COORD_BITS = lpd_pkg::COORD_BITS_DEF,
	parameter int SUM_BITS   = lpd_pkg::SUM_BITS_DEF,
	parameter int OUT_W      = ((COORD_BITS + SUM_BITS + 7) / 8) * 8
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [OUT_W-1:0]            m_tdata,
	input logic                        m_tlast
);
	import lpd_pkg::*;

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (in_acc && !out_acc)
			pend_q <= pend_q + 1'b1;
		else if (out_acc && !in_acc)
			pend_q <= pend_q - 1'b1;
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input ready right after an accepted word");

	a_no_phantom_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pend_q != 2'd0))
		else $error("output word with no accepted input");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two words in flight");

	a_energy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[COORD_BITS +: SUM_BITS] == '0))
		else $error("energy nonzero on a non-final word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output word changed");

endmodule

bind p_norm_distance_energy_gradient lpd_checker #(
	.COORD_BITS(COORD_BITS),
	.SUM_BITS  (SUM_BITS)
) u_lpd_checker (.*);

/* verif/tb_p_norm_distance_energy_gradient.sv */
`timescale 1ns / 1ps
// Testbench for p_norm_distance_energy_gradient: directed and random coordinate streams at
// every order, random idling on both stream sides, checked against an in-bench predictor.
// Depends on lpd_pkg and the block's RTL only.
module tb_p_norm_distance_energy_gradient;
	import lpd_pkg::*;

	localparam int CW    = COORD_BITS_DEF;
	localparam int FW    = FRAC_BITS_DEF;
	localparam int SW    = SUM_BITS_DEF;
	localparam int IN_W  = ((2 * CW + 7) / 8) * 8;
	localparam int OUT_W = ((CW + SW + 7) / 8) * 8;

	localparam logic [SW-1:0]        SUM_MAX      = '1;
	localparam logic [SW-1:0]        GRAD_POS_LIM = (SW'(1) << (CW - 1)) - 1;
	localparam logic [SW-1:0]        GRAD_NEG_LIM = SW'(1) << (CW - 1);
	localparam logic signed [CW-1:0] COORD_MIN    = {1'b1, {(CW - 1){1'b0}}};
	localparam logic signed [CW-1:0] COORD_MAX    = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0] ONE_Q        = CW'(1) << FW;

	localparam int HOLD_LEN    = 250;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 100;

	typedef struct {
		logic [CW-1:0] grad;
		logic [SW-1:0] energy;
		logic          fin;
	} lp_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata   = '0;  // coordinate, target_coordinate
	logic               s_tlast   = 1'b0;  // last
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [OUT_W-1:0]   m_tdata;  // gradient_element, energy_value
	logic               m_tlast;  // final_res
	logic               cfg_wen   = 1'b0;
	logic [ORDER_W-1:0] cfg_wdata = '0;

	// predictor state
	logic [ORDER_W-1:0] lp_order     = ORDER_RESET;
	logic [SW-1:0]      lp_power_sum = '0;
	lp_result_t         result_q[$];

	int  mismatches   = 0;
	int  quiet_cycles = 0;
	bit  idle_on      = 1'b1;
	int  hold_req     = 0;
	int  hold_seen    = 0;
	int  hold_left    = 0;
	int  stall_left   = 0;

	p_norm_distance_energy_gradient #(
		.COORD_BITS(CW),
		.FRAC_BITS(FW),
		.SUM_BITS(SW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// (a*b) >> FW, truncated, saturated to the sum width
	function automatic logic [SW-1:0] frac_mul_sat(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [2*SW-1:0] prod;
		prod = a * b;
		prod = prod >> FW;
		return (prod[2*SW-1:SW] != '0) ? SUM_MAX : prod[SW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] edge_coord();
		case ($urandom_range(0, 4))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3: return '1;
			default: return CW'($urandom());
		endcase
	endfunction

	task automatic predict_word(input logic signed [CW-1:0] c, input logic signed [CW-1:0] t,
			input logic lst);
		longint        diff;
		logic [SW-1:0] mag, pw, term, clip;
		logic [SW:0]   acc;
		int            k;
		lp_result_t    r;
		diff = longint'(c) - longint'(t);
		mag  = (diff < 0) ? SW'(-diff) : SW'(diff);
		pw   = mag;
		for (k = 2; k < lp_order; k++)
			pw = frac_mul_sat(pw, mag);
		term = frac_mul_sat(pw, mag);
		// gradient magnitude is |d|^(p-1), sign of d applied after clipping
		if (diff < 0) begin
			clip   = (pw > GRAD_NEG_LIM) ? GRAD_NEG_LIM : pw;
			clip   = -clip;
			r.grad = clip[CW-1:0];
		end else begin
			clip   = (pw > GRAD_POS_LIM) ? GRAD_POS_LIM : pw;
			r.grad = clip[CW-1:0];
		end
		acc          = {1'b0, lp_power_sum} + {1'b0, term};
		lp_power_sum = acc[SW] ? SUM_MAX : acc[SW-1:0];
		r.fin        = lst;
		r.energy     = '0;
		if (lst) begin
			r.energy     = lp_power_sum / lp_order;
			lp_power_sum = '0;
		end
		result_q.insert(result_q.size(), r);
	endtask

	task automatic send_word(input logic signed [CW-1:0] c, input logic signed [CW-1:0] t,
			input logic lst);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({t, c});
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		predict_word(c, t, lst);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	// waits for the block to go idle, then writes the order register
	task automatic write_order(input logic [ORDER_W-1:0] v);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen  <= 1'b0;
		lp_order  = (v < ORDER_MIN) ? ORDER_MIN : (v > ORDER_MAX) ? ORDER_MAX : v;
	endtask

	task automatic pick_pair(output logic signed [CW-1:0] c, output logic signed [CW-1:0] t);
		int     sel, shift;
		longint base, delta;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			// close pair, difference spread over all scales
			shift = $urandom_range(0, CW - 2);
			delta = $urandom_range(0, 1 << shift);
			if ($urandom_range(0, 1))
				delta = -delta;
			t    = CW'($urandom());
			base = longint'(t) + delta;
			if (base > COORD_MAX || base < COORD_MIN)
				base = longint'(t) - delta;
			c = CW'(base);
		end else if (sel < 8) begin
			c = CW'($urandom());
			t = CW'($urandom());
		end else begin
			c = edge_coord();
			t = edge_coord();
		end
	endtask

	task automatic send_vectors(input int n);
		int                   sent, len, k;
		logic signed [CW-1:0] c, t;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			for (k = 0; k < len; k++) begin
				pick_pair(c, t);
				send_word(c, t, k == len - 1);
				sent++;
			end
		end
	endtask

	task automatic test_reset_order_extremes();
		send_word(COORD_MAX, COORD_MIN, 1'b0);
		send_word(COORD_MIN, COORD_MAX, 1'b0);
		send_word('0, '0, 1'b0);
		send_word(ONE_Q, '0, 1'b1);
		send_word('1, '0, 1'b1);
	endtask

	task automatic test_order_clamp_saturation();
		write_order(4'd0);
		send_word(ONE_Q <<< 1, '0, 1'b1);
		write_order(4'd15);
		// 256^8 overflows the higher powers and the sum
		send_word(COORD_MAX, COORD_MIN, 1'b0);
		send_word(COORD_MIN, COORD_MAX, 1'b0);
		send_word(ONE_Q + (ONE_Q >>> 1), '0, 1'b1);
		write_order(4'd9);
		send_word(ONE_Q >>> 1, -(ONE_Q >>> 1), 1'b1);
		write_order(4'd1);
		send_word(-ONE_Q, ONE_Q, 1'b1);
		write_order(4'd3);
		send_word(COORD_MIN, '0, 1'b1);
		write_order(4'd8);
		send_word(ONE_Q >>> 8, '0, 1'b0);
		send_word(COORD_MAX, COORD_MAX, 1'b1);
	endtask

	task automatic test_random_orders();
		int ph;
		for (ph = 0; ph < 8; ph++) begin
			write_order((ph < 7) ? ORDER_W'(ph + 2) : ORDER_W'($urandom_range(0, 15)));
			send_vectors(70);
		end
	endtask

	task automatic test_output_backpressure();
		hold_req++;
		send_vectors(12);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		write_order(4'd5);
		send_vectors(60);
	endtask

	// result check and ready generation
	always @(posedge clk) begin : rx_side
		lp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual grad=%h energy=%h final=%b",
					$time, m_tdata[CW-1:0], m_tdata[CW+SW-1:CW], m_tlast);
				mismatches++;
			end else begin
				want = result_q.pop_front();
				if (m_tdata[CW-1:0] !== want.grad) begin
					$display("%0t: gradient_element expected %h actual %h",
						$time, want.grad, m_tdata[CW-1:0]);
					mismatches++;
				end
				if (m_tdata[CW+SW-1:CW] !== want.energy) begin
					$display("%0t: energy_value expected %h actual %h",
						$time, want.energy, m_tdata[CW+SW-1:CW]);
					mismatches++;
				end
				if (m_tlast !== want.fin) begin
					$display("%0t: final_res expected %b actual %b", $time, want.fin, m_tlast);
					mismatches++;
				end
			end
		end
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_order_extremes();
		test_order_clamp_saturation();
		test_random_orders();
		test_output_backpressure();
		test_no_idle();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && result_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
